### hdl/rbf_pkg.sv
// Shared codes, payload types and controller types for the redundant bind filter.
package rbf_pkg;

    localparam logic [3:0] REQ_BIND_TEX  = 4'd0;
    localparam logic [3:0] REQ_USE_PROG  = 4'd1;
    localparam logic [3:0] REQ_BIND_VA   = 4'd2;
    localparam logic [3:0] REQ_BIND_BUF  = 4'd3;
    localparam logic [3:0] REQ_DEL_TEX   = 4'd4;
    localparam logic [3:0] REQ_DEL_PROG  = 4'd5;
    localparam logic [3:0] REQ_DEL_VA    = 4'd6;
    localparam logic [3:0] REQ_DEL_BUF   = 4'd7;
    localparam logic [3:0] REQ_INV_ALL   = 4'd8;
    localparam logic [3:0] REQ_RESET_CNT = 4'd9;

    localparam logic [1:0] KIND_TEX  = 2'd0;
    localparam logic [1:0] KIND_PROG = 2'd1;
    localparam logic [1:0] KIND_VA   = 2'd2;
    localparam logic [1:0] KIND_BUF  = 2'd3;

    localparam logic [1:0] TGT_ARRAY   = 2'd0;
    localparam logic [1:0] TGT_ELEMENT = 2'd1;

    localparam logic [31:0] NAME_MARK = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [7:0]  unit;
        logic [1:0]  buffer_target;
        logic [31:0] object_name;
    } req_t;

    typedef struct packed {
        logic        select_unit;
        logic [3:0]  unit_out;
        logic        bind_out;
        logic [1:0]  bind_kind;
        logic [1:0]  target_out;
        logic [31:0] name_out;
        logic        was_skipped;
        logic        dropped;
        logic [31:0] skip_count;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_del_tex;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/rbf_req_if.sv
// Request channel: valid/ready handshake carrying one bind request beat.
interface rbf_req_if;
    import rbf_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/rbf_res_if.sv
// Result channel: valid/ready handshake carrying one filter result beat.
interface rbf_res_if;
    import rbf_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/redundant_bind_filter_unit.sv
// A request is registered on acceptance and executed once the output register is free; a
// texture delete first scans the texture unit table serially through its single RAM read port.
// A new request is taken only when the controller is idle, after the last one has executed.
// The result sits in an output register; the next request is taken while it waits.
// Reset: asynchronous, active low; all bind state reads as zero at once (per-unit
// valid and mark flags), no clearing pass.
module redundant_bind_filter_unit #(
    parameter int TEXTURE_UNITS = 16
) (
    input logic   clk,
    input logic   rst_n,
    rbf_req_if.sink   req,
    rbf_res_if.source res
);
    import rbf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    rbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rbf_dpath #(
        .TEXTURE_UNITS (TEXTURE_UNITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (req.data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (res.valid),
        .out_data  (res.data),
        .out_ready (res.ready)
    );

    assign req.ready = in_ready;

endmodule

### hdl/rbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

### hdl/rbf_ctrl.sv
// Controller state machine: accept, texture delete scan, execute and hand off.
module rbf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbf_pkg::dp_status_t status,
    output rbf_pkg::ctrl_cmd_t  cmd
);
    import rbf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_del_tex ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN:
            begin
                // walk one texture unit per cycle
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the output register can take the beat
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/rbf_dpath.sv
// Datapath: bind state, texture unit table, filter decision and result register.
module rbf_dpath #(
    parameter int TEXTURE_UNITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rbf_pkg::req_t       in_data,
    input  rbf_pkg::ctrl_cmd_t  cmd,
    output rbf_pkg::dp_status_t status,
    output logic                out_valid,
    output rbf_pkg::res_t       out_data,
    input  logic                out_ready
);
    import rbf_pkg::*;

    localparam int UNIT_W = (TEXTURE_UNITS > 1) ? $clog2(TEXTURE_UNITS) : 1;

    req_t                     req_reg;
    logic [UNIT_W-1:0]        scan_idx_reg;
    logic [TEXTURE_UNITS-1:0] valid_reg, valid_next;
    logic [TEXTURE_UNITS-1:0] mark_reg, mark_next;
    logic                     known_reg, known_next;
    logic [UNIT_W-1:0]        active_reg, active_next;
    logic [31:0]              prog_reg, prog_next;
    logic [31:0]              va_reg, va_next;
    logic [31:0]              buf0_reg, buf0_next;
    logic [31:0]              buf1_reg, buf1_next;
    logic [31:0]              count_reg, count_next;
    logic                     out_valid_reg;
    res_t                     out_data_reg;
    res_t                     res;

    logic              wr_en;
    logic [UNIT_W-1:0] rd_addr;
    logic [31:0]       rd_data;
    logic              in_range_new;
    logic              in_range;
    logic [UNIT_W-1:0] tex_idx;
    logic [31:0]       tex_value;
    logic [31:0]       scan_value;
    logic              scan_last;
    logic              same_unit;

    assign in_range_new = ({1'b0, in_data.unit} < 9'(TEXTURE_UNITS));
    assign in_range     = ({1'b0, req_reg.unit} < 9'(TEXTURE_UNITS));
    assign tex_idx      = in_range ? req_reg.unit[UNIT_W-1:0] : '0;
    assign scan_last    = (scan_idx_reg == UNIT_W'(TEXTURE_UNITS - 1));

    // an entry reads as the mark once marked, as zero until first written
    assign tex_value  = mark_reg[tex_idx] ? NAME_MARK :
                        (valid_reg[tex_idx] ? rd_data : 32'd0);
    assign scan_value = mark_reg[scan_idx_reg] ? NAME_MARK :
                        (valid_reg[scan_idx_reg] ? rd_data : 32'd0);
    assign same_unit  = known_reg && (active_reg == tex_idx);

    always_comb
    begin
        if (cmd.load)
        begin
            rd_addr = (in_data.req_type == REQ_BIND_TEX && in_range_new) ?
                      in_data.unit[UNIT_W-1:0] : '0;
        end
        else if (cmd.scan_step && !scan_last)
        begin
            rd_addr = scan_idx_reg + UNIT_W'(1);
        end
        else
        begin
            // keep the held request's entry on the read port while execute stalls
            rd_addr = tex_idx;
        end
    end

    rbf_ram #(
        .WIDTH (32),
        .DEPTH (TEXTURE_UNITS)
    ) u_tex_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tex_idx),
        .wr_data (req_reg.object_name),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        res         = '0;
        wr_en       = 1'b0;
        valid_next  = valid_reg;
        mark_next   = mark_reg;
        known_next  = known_reg;
        active_next = active_reg;
        prog_next   = prog_reg;
        va_next     = va_reg;
        buf0_next   = buf0_reg;
        buf1_next   = buf1_reg;
        count_next  = count_reg;

        if (cmd.scan_step && scan_value == req_reg.object_name)
        begin
            mark_next[scan_idx_reg] = 1'b1;
        end

        if (cmd.exec)
        begin
            unique case (req_reg.req_type)
                REQ_BIND_TEX:
                begin
                    if (!in_range)
                    begin
                        res.dropped = 1'b1;
                    end
                    else if (tex_value == req_reg.object_name && same_unit)
                    begin
                        res.was_skipped = 1'b1;
                    end
                    else
                    begin
                        if (!same_unit)
                        begin
                            res.select_unit = 1'b1;
                            res.unit_out    = req_reg.unit[3:0];
                            known_next      = 1'b1;
                            active_next     = tex_idx;
                        end
                        res.bind_out       = 1'b1;
                        res.bind_kind      = KIND_TEX;
                        res.name_out       = req_reg.object_name;
                        wr_en              = 1'b1;
                        valid_next[tex_idx] = 1'b1;
                        mark_next[tex_idx]  = 1'b0;
                    end
                end
                REQ_USE_PROG:
                begin
                    if (prog_reg == req_reg.object_name)
                    begin
                        res.was_skipped = 1'b1;
                    end
                    else
                    begin
                        res.bind_out  = 1'b1;
                        res.bind_kind = KIND_PROG;
                        res.name_out  = req_reg.object_name;
                        prog_next     = req_reg.object_name;
                    end
                end
                REQ_BIND_VA:
                begin
                    if (va_reg == req_reg.object_name)
                    begin
                        res.was_skipped = 1'b1;
                    end
                    else
                    begin
                        res.bind_out  = 1'b1;
                        res.bind_kind = KIND_VA;
                        res.name_out  = req_reg.object_name;
                        va_next       = req_reg.object_name;
                        buf1_next     = NAME_MARK;
                    end
                end
                REQ_BIND_BUF:
                begin
                    if ((req_reg.buffer_target == TGT_ARRAY &&
                         buf0_reg == req_reg.object_name) ||
                        (req_reg.buffer_target == TGT_ELEMENT &&
                         buf1_reg == req_reg.object_name))
                    begin
                        res.was_skipped = 1'b1;
                    end
                    else
                    begin
                        if (req_reg.buffer_target == TGT_ARRAY)
                        begin
                            buf0_next = req_reg.object_name;
                        end
                        if (req_reg.buffer_target == TGT_ELEMENT)
                        begin
                            buf1_next = req_reg.object_name;
                        end
                        res.bind_out   = 1'b1;
                        res.bind_kind  = KIND_BUF;
                        res.target_out = req_reg.buffer_target;
                        res.name_out   = req_reg.object_name;
                    end
                end
                REQ_DEL_PROG:
                begin
                    if (prog_reg == req_reg.object_name)
                    begin
                        prog_next = NAME_MARK;
                    end
                end
                REQ_DEL_VA:
                begin
                    if (va_reg == req_reg.object_name)
                    begin
                        va_next = NAME_MARK;
                    end
                end
                REQ_DEL_BUF:
                begin
                    if (buf0_reg == req_reg.object_name)
                    begin
                        buf0_next = NAME_MARK;
                    end
                    if (buf1_reg == req_reg.object_name)
                    begin
                        buf1_next = NAME_MARK;
                    end
                end
                REQ_INV_ALL:
                begin
                    mark_next   = '1;
                    known_next  = 1'b0;
                    active_next = '0;
                    prog_next   = NAME_MARK;
                    va_next     = NAME_MARK;
                    buf0_next   = NAME_MARK;
                    buf1_next   = NAME_MARK;
                end
                REQ_RESET_CNT:
                begin
                    count_next = 32'd0;
                end
                default:
                begin
                    // texture delete finished during the scan; unused codes do nothing
                end
            endcase
            if (res.was_skipped)
            begin
                count_next = count_reg + 32'd1;
            end
        end
        res.skip_count = count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
        if (cmd.exec)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            valid_reg     <= '0;
            mark_reg      <= '0;
            known_reg     <= 1'b0;
            active_reg    <= '0;
            prog_reg      <= 32'd0;
            va_reg        <= 32'd0;
            buf0_reg      <= 32'd0;
            buf1_reg      <= 32'd0;
            count_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_step && !scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + UNIT_W'(1);
            end
            valid_reg  <= valid_next;
            mark_reg   <= mark_next;
            known_reg  <= known_next;
            active_reg <= active_next;
            prog_reg   <= prog_next;
            va_reg     <= va_next;
            buf0_reg   <= buf0_next;
            buf1_reg   <= buf1_next;
            count_reg  <= count_next;
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.in_del_tex = (in_data.req_type == REQ_DEL_TEX);
    assign status.scan_last  = scan_last;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_data          = out_data_reg;

`ifndef ASSERT_OFF
    a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");
    a_exec_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("executed request produced no result beat");
    a_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.was_skipped && out_data_reg.bind_out))
        else $error("result both skipped and forwarded");
    a_select_tex: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.select_unit) |->
        (out_data_reg.bind_out && out_data_reg.bind_kind == KIND_TEX))
        else $error("unit select without a texture bind");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && res.was_skipped) |=> (count_reg == $past(count_reg) + 32'd1))
        else $error("skip count did not advance");
`endif

endmodule

### bench/tb_redundant_bind_filter_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for the redundant bind filter: directed table, random traffic, scoreboard.
module tb_redundant_bind_filter_unit;
    import rbf_pkg::*;

    localparam int          TEXTURE_UNITS = 16;
    localparam logic [3:0]  REQ_UNUSED_LO = 4'd10;
    localparam logic [3:0]  REQ_UNUSED_HI = 4'd15;
    localparam int          PHASE_ITEMS   = 300;
    localparam int          LONG_HOLD     = 400;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef struct {
        req_t rq;
        bit   lit;
        res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    rbf_req_if req_ch ();
    rbf_res_if res_ch ();

    redundant_bind_filter_unit #(
        .TEXTURE_UNITS(TEXTURE_UNITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .res  (res_ch)
    );

    // Shadow copy of the filter state
    logic [31:0] tex_bound [TEXTURE_UNITS];
    logic [31:0] buf_bound [2];
    logic        act_known;
    logic [3:0]  act_unit;
    logic [31:0] prog_bound;
    logic [31:0] va_bound;
    logic [31:0] skip_total;

    res_t        filter_results_due[$];
    dir_row_t    dir_rows[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          pressure_req;
    int unsigned cycles;

    function automatic req_t mk_req(logic [3:0] t, logic [7:0] u, logic [1:0] g,
                                    logic [31:0] n);
        req_t r;
        r.req_type      = t;
        r.unit          = u;
        r.buffer_target = g;
        r.object_name   = n;
        return r;
    endfunction

    function automatic res_t mk_res(logic sel, logic [3:0] uo, logic bnd, logic [1:0] kind,
                                    logic [1:0] tgt, logic [31:0] n, logic skp, logic drp,
                                    logic [31:0] cnt);
        res_t o;
        o.select_unit = sel;
        o.unit_out    = uo;
        o.bind_out    = bnd;
        o.bind_kind   = kind;
        o.target_out  = tgt;
        o.name_out    = n;
        o.was_skipped = skp;
        o.dropped     = drp;
        o.skip_count  = cnt;
        return o;
    endfunction

    function automatic dir_row_t row_lit(req_t r, res_t w);
        dir_row_t d;
        d.rq   = r;
        d.lit  = 1'b1;
        d.want = w;
        return d;
    endfunction

    function automatic dir_row_t row_pred(req_t r);
        dir_row_t d;
        d.rq   = r;
        d.lit  = 1'b0;
        d.want = '0;
        return d;
    endfunction

    // Advance the shadow state by one request and return the result it causes.
    function automatic res_t predict_filter(req_t r);
        res_t o;
        logic same_unit;
        logic [3:0] u;
        o = '0;
        u = r.unit[3:0];
        case (r.req_type)
            REQ_BIND_TEX: begin
                if (r.unit >= TEXTURE_UNITS) begin
                    o.dropped = 1'b1;
                end
                else begin
                    same_unit = act_known && act_unit == u;
                    if (tex_bound[u] == r.object_name && same_unit) begin
                        o.was_skipped = 1'b1;
                    end
                    else begin
                        if (!same_unit) begin
                            o.select_unit = 1'b1;
                            o.unit_out    = u;
                            act_known     = 1'b1;
                            act_unit      = u;
                        end
                        o.bind_out   = 1'b1;
                        o.bind_kind  = KIND_TEX;
                        o.name_out   = r.object_name;
                        tex_bound[u] = r.object_name;
                    end
                end
            end
            REQ_USE_PROG: begin
                if (prog_bound == r.object_name) begin
                    o.was_skipped = 1'b1;
                end
                else begin
                    o.bind_out  = 1'b1;
                    o.bind_kind = KIND_PROG;
                    o.name_out  = r.object_name;
                    prog_bound  = r.object_name;
                end
            end
            REQ_BIND_VA: begin
                if (va_bound == r.object_name) begin
                    o.was_skipped = 1'b1;
                end
                else begin
                    o.bind_out   = 1'b1;
                    o.bind_kind  = KIND_VA;
                    o.name_out   = r.object_name;
                    va_bound     = r.object_name;
                    buf_bound[1] = NAME_MARK;
                end
            end
            REQ_BIND_BUF: begin
                if (r.buffer_target <= TGT_ELEMENT &&
                    buf_bound[r.buffer_target[0]] == r.object_name) begin
                    o.was_skipped = 1'b1;
                end
                else begin
                    if (r.buffer_target <= TGT_ELEMENT)
                        buf_bound[r.buffer_target[0]] = r.object_name;
                    o.bind_out   = 1'b1;
                    o.bind_kind  = KIND_BUF;
                    o.target_out = r.buffer_target;
                    o.name_out   = r.object_name;
                end
            end
            REQ_DEL_TEX: begin
                foreach (tex_bound[i])
                    if (tex_bound[i] == r.object_name) tex_bound[i] = NAME_MARK;
            end
            REQ_DEL_PROG: begin
                if (prog_bound == r.object_name) prog_bound = NAME_MARK;
            end
            REQ_DEL_VA: begin
                if (va_bound == r.object_name) va_bound = NAME_MARK;
            end
            REQ_DEL_BUF: begin
                if (buf_bound[0] == r.object_name) buf_bound[0] = NAME_MARK;
                if (buf_bound[1] == r.object_name) buf_bound[1] = NAME_MARK;
            end
            REQ_INV_ALL: begin
                foreach (tex_bound[i]) tex_bound[i] = NAME_MARK;
                buf_bound[0] = NAME_MARK;
                buf_bound[1] = NAME_MARK;
                act_known    = 1'b0;
                act_unit     = '0;
                prog_bound   = NAME_MARK;
                va_bound     = NAME_MARK;
            end
            REQ_RESET_CNT: begin
                skip_total = '0;
            end
            default: begin
            end
        endcase
        if (o.was_skipped) skip_total = skip_total + 32'd1;
        o.skip_count = skip_total;
        return o;
    endfunction

    // Mostly well-formed binds over a small name pool so redundancy is common.
    function automatic req_t random_request();
        req_t r;
        int pick;
        int sel;
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        if (sel < 50)      r.unit = 8'($urandom_range(1));
        else if (sel < 85) r.unit = 8'($urandom_range(TEXTURE_UNITS - 1));
        else               r.unit = 8'($urandom_range(255));
        sel = $urandom_range(99);
        if (sel < 60)      r.object_name = 32'($urandom_range(3));
        else if (sel < 70) r.object_name = NAME_MARK;
        else               r.object_name = $urandom;
        r.buffer_target = 2'($urandom_range(3));
        if (pick < 30)      r.req_type = REQ_BIND_TEX;
        else if (pick < 45) r.req_type = REQ_USE_PROG;
        else if (pick < 55) r.req_type = REQ_BIND_VA;
        else if (pick < 75) r.req_type = REQ_BIND_BUF;
        else if (pick < 79) r.req_type = REQ_DEL_TEX;
        else if (pick < 82) r.req_type = REQ_DEL_PROG;
        else if (pick < 85) r.req_type = REQ_DEL_VA;
        else if (pick < 88) r.req_type = REQ_DEL_BUF;
        else if (pick < 90) r.req_type = REQ_INV_ALL;
        else if (pick < 92) r.req_type = REQ_RESET_CNT;
        else if (pick < 95) r.req_type = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        else                r.req_type = 4'($urandom_range(15));
        return r;
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_req(req_t r, bit lit, res_t want);
        res_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data  = r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        pred = predict_filter(r);
        filter_results_due.push_back(lit ? want : pred);
        @(negedge clk);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        res_ch.ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (pressure_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else begin
                res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        res_t want;
        res_t got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (filter_results_due.size() == 0) begin
                $error("result beat with nothing expected: 0x%0h", got);
                mismatches++;
            end
            else begin
                want = filter_results_due.pop_front();
                check_field("select_unit", 32'(want.select_unit), 32'(got.select_unit));
                check_field("unit_out",    32'(want.unit_out),    32'(got.unit_out));
                check_field("bind_out",    32'(want.bind_out),    32'(got.bind_out));
                check_field("bind_kind",   32'(want.bind_kind),   32'(got.bind_kind));
                check_field("target_out",  32'(want.target_out),  32'(got.target_out));
                check_field("name_out",    want.name_out,         got.name_out);
                check_field("was_skipped", 32'(want.was_skipped), 32'(got.was_skipped));
                check_field("dropped",     32'(want.dropped),     32'(got.dropped));
                check_field("skip_count",  want.skip_count,       got.skip_count);
            end
        end
    end

    initial begin
        foreach (tex_bound[i]) tex_bound[i] = '0;
        buf_bound[0]   = '0;
        buf_bound[1]   = '0;
        act_known      = 1'b0;
        act_unit       = '0;
        prog_bound     = '0;
        va_bound       = '0;
        skip_total     = '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_req   = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rst_n          = 1'b0;

        // Texture binds from reset: unknown active unit, repeat, out-of-range units; then program uses
        dir_rows.push_back(row_lit(mk_req(REQ_BIND_TEX, 8'd0, TGT_ARRAY, 32'd0),
                                   mk_res(1'b1, 4'd0, 1'b1, KIND_TEX, '0, 32'd0,
                                          1'b0, 1'b0, 32'd0)));
        dir_rows.push_back(row_lit(mk_req(REQ_BIND_TEX, 8'd0, TGT_ARRAY, 32'd0),
                                   mk_res(1'b0, '0, 1'b0, '0, '0, 32'd0,
                                          1'b1, 1'b0, 32'd1)));
        dir_rows.push_back(row_lit(mk_req(REQ_BIND_TEX, 8'd16, TGT_ARRAY, 32'd5),
                                   mk_res(1'b0, '0, 1'b0, '0, '0, 32'd0,
                                          1'b0, 1'b1, 32'd1)));
        dir_rows.push_back(row_lit(mk_req(REQ_BIND_TEX, 8'd255, 2'd3, NAME_MARK),
                                   mk_res(1'b0, '0, 1'b0, '0, '0, 32'd0,
                                          1'b0, 1'b1, 32'd1)));
        dir_rows.push_back(row_lit(mk_req(REQ_BIND_TEX, 8'd15, TGT_ARRAY, NAME_MARK),
                                   mk_res(1'b1, 4'd15, 1'b1, KIND_TEX, '0, NAME_MARK,
                                          1'b0, 1'b0, 32'd1)));
        dir_rows.push_back(row_lit(mk_req(REQ_USE_PROG, 8'd0, TGT_ARRAY, 32'd0),
                                   mk_res(1'b0, '0, 1'b0, '0, '0, 32'd0,
                                          1'b1, 1'b0, 32'd2)));
        dir_rows.push_back(row_pred(mk_req(REQ_USE_PROG, 8'd0, TGT_ARRAY, NAME_MARK)));
        // A vertex array bind marks the element slot, so binding the mark skips
        dir_rows.push_back(row_pred(mk_req(REQ_BIND_VA, 8'd0, TGT_ARRAY, 32'd7)));
        dir_rows.push_back(row_pred(mk_req(REQ_BIND_BUF, 8'd0, TGT_ELEMENT, NAME_MARK)));
        dir_rows.push_back(row_pred(mk_req(REQ_BIND_BUF, 8'd0, TGT_ARRAY, 32'd0)));
        dir_rows.push_back(row_pred(mk_req(REQ_BIND_BUF, 8'd0, 2'd2, 32'd0)));
        dir_rows.push_back(row_pred(mk_req(REQ_BIND_BUF, 8'd0, 2'd3, 32'd0)));
        dir_rows.push_back(row_pred(mk_req(REQ_DEL_TEX, 8'd0, TGT_ARRAY, NAME_MARK)));
        dir_rows.push_back(row_pred(mk_req(REQ_DEL_PROG, 8'd0, TGT_ARRAY, NAME_MARK)));
        dir_rows.push_back(row_pred(mk_req(REQ_DEL_VA, 8'd0, TGT_ARRAY, 32'd7)));
        dir_rows.push_back(row_pred(mk_req(REQ_DEL_BUF, 8'd0, TGT_ARRAY, 32'd0)));
        dir_rows.push_back(row_pred(mk_req(REQ_INV_ALL, 8'd0, TGT_ARRAY, 32'd0)));
        // Marked entry matches the name but the active unit is unknown: select and bind
        dir_rows.push_back(row_pred(mk_req(REQ_BIND_TEX, 8'd15, TGT_ARRAY, NAME_MARK)));
        dir_rows.push_back(row_pred(mk_req(REQ_USE_PROG, 8'd0, TGT_ARRAY, NAME_MARK)));
        dir_rows.push_back(row_lit(mk_req(REQ_RESET_CNT, 8'd0, TGT_ARRAY, 32'd0),
                                   mk_res(1'b0, '0, 1'b0, '0, '0, 32'd0,
                                          1'b0, 1'b0, 32'd0)));
        dir_rows.push_back(row_lit(mk_req(REQ_UNUSED_LO, 8'd3, TGT_ELEMENT, 32'd9),
                                   mk_res(1'b0, '0, 1'b0, '0, '0, 32'd0,
                                          1'b0, 1'b0, 32'd0)));
        dir_rows.push_back(row_lit(mk_req(REQ_UNUSED_HI, 8'd255, 2'd3, NAME_MARK),
                                   mk_res(1'b0, '0, 1'b0, '0, '0, 32'd0,
                                          1'b0, 1'b0, 32'd0)));
        dir_rows.push_back(row_pred(mk_req(REQ_BIND_TEX, 8'd3, 2'd2, 32'hA5A5_5A5A)));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].rq, dir_rows[i].lit, dir_rows[i].want);

        repeat (PHASE_ITEMS) send_req(random_request(), 1'b0, '0);
        send_idle_pct = 70;
        repeat (PHASE_ITEMS) send_req(random_request(), 1'b0, '0);
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        repeat (PHASE_ITEMS) send_req(random_request(), 1'b0, '0);
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        repeat (PHASE_ITEMS) send_req(random_request(), 1'b0, '0);
        // Long receiver hold-off while the sender keeps offering beats
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_req   = 1'b1;
        repeat (60) send_req(random_request(), 1'b0, '0);

        req_ch.valid = 1'b0;
        while (filter_results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
hdl/rbf_pkg.sv
hdl/rbf_req_if.sv
hdl/rbf_res_if.sv
hdl/rbf_ram.sv
hdl/rbf_ctrl.sv
hdl/rbf_dpath.sv
hdl/redundant_bind_filter_unit.sv
bench/tb_redundant_bind_filter_unit.sv
